// ----- rtl/brace_group_tokenizer_core_macros.svh -----
// Assertion macros for the brace group tokenizer.
// Used by the top level; needs a clock named clk and a reset named arst_n in scope.
`ifndef BRACE_GROUP_TOKENIZER_CORE_MACROS_SVH
`define BRACE_GROUP_TOKENIZER_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define BGT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define BGT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bgt_pkg.sv -----
// Shared types and constants for the brace group tokenizer.
// No dependencies; used by bgt_scan and brace_group_tokenizer_core.
package bgt_pkg;

	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_ESC   = 8'h5C;

	localparam int QAW    = 2;
	localparam int QDEPTH = 1 << QAW;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_WORD  = 2'd1,
		MODE_GROUP = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_STRAY    = 3'd1,
		ST_UNTERM   = 3'd2,
		ST_DANGLING = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic [15:0] offset;
		logic [16:0] length;
		logic        kind;
		status_t     status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] n_res;
		result_t    r0;
		result_t    r1;
		logic       idle;
	} scan_out_t;

	function automatic logic is_blank(input logic [7:0] b);
		is_blank = b inside {8'h20, [8'h09:8'h0D]};
	endfunction

endpackage

// ----- rtl/brace_group_tokenizer_core.sv -----
// Top level of the brace group tokenizer: input register, scanner, result queue.
// Depends on bgt_pkg, bgt_scan and brace_group_tokenizer_core_macros.svh.
//
//  channel | signals                                              | moves
//  --------+------------------------------------------------------+---------------------
//  in      | in_valid, in_ready, text_byte, end_of_text           | one text byte
//  out     | out_valid, out_ready, token_offset, token_length,    | one token or status
//          | token_kind, status, last_of_run                      |
//
// Flow: one byte per cycle while the queue has room for two results; a byte is taken
//   into the input register, scanned there, and its results leave through the queue.
// A byte that causes two results presents them at the output one after the other.
// The four-entry result queue sets the throughput: the input register advances only
//   while the queue has room for two results.
// Reset (arst_n low) clears the scanner to between tokens at position zero and empties
//   the queue; no clearing pass is needed.
`include "brace_group_tokenizer_core_macros.svh"

module brace_group_tokenizer_core #(
	parameter int MAX_TEXT_BYTES = 65536,
	parameter int MAX_NESTING    = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] token_offset,
	output logic [16:0] token_length,
	output logic        token_kind,
	output logic [2:0]  status,
	output logic        last_of_run
);

	localparam int QCW = bgt_pkg::QAW + 1;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       adv;

	// Result queue.
	bgt_pkg::result_t              q_q [bgt_pkg::QDEPTH];
	logic [bgt_pkg::QAW-1:0]       wp_q, rp_q;
	logic [QCW-1:0]                q_cnt_q;
	logic                          pop;
	logic [QCW-1:0]                n_push;

	bgt_pkg::scan_out_t scan;
	bgt_pkg::result_t   head;

	// Advance the stage only when the queue can take a full pair of results.
	assign adv      = valid_s1 && (q_cnt_q <= QCW'(bgt_pkg::QDEPTH - 2));
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the stage: hold while stalled.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	bgt_scan #(
		.MAX_TEXT_BYTES (MAX_TEXT_BYTES),
		.MAX_NESTING    (MAX_NESTING)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.scan        (scan)
	);

	assign n_push = adv ? QCW'(scan.n_res) : '0;
	assign pop    = out_valid && out_ready;

	// Queue control: push zero, one or two results, drop the head on pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			q_cnt_q <= '0;
		end else begin
			wp_q    <= wp_q + n_push[bgt_pkg::QAW-1:0];
			rp_q    <= rp_q + bgt_pkg::QAW'(pop);
			q_cnt_q <= q_cnt_q + n_push - QCW'(pop);
		end
	end

	// Queue storage: results in order, first at the write pointer.
	always_ff @(posedge clk) begin
		if (n_push != '0) begin
			q_q[wp_q] <= scan.r0;
		end
		if (n_push == QCW'(2)) begin
			q_q[wp_q + bgt_pkg::QAW'(1)] <= scan.r1;
		end
	end

	assign head         = q_q[rp_q];
	assign out_valid    = (q_cnt_q != '0);
	assign token_offset = head.offset;
	assign token_length = head.length;
	assign token_kind   = head.kind;
	assign status       = head.status;
	assign last_of_run  = head.last;

	// The queue never overflows.
	`BGT_ASSERT_SAME(a_queue_bound, 1'b1, q_cnt_q <= QCW'(bgt_pkg::QDEPTH), "result queue overflow")
	// A scanned byte never pushes past the queue's room.
	`BGT_ASSERT_SAME(a_push_room, adv, (q_cnt_q + QCW'(scan.n_res)) <= QCW'(bgt_pkg::QDEPTH), "push without room")
	// After the last byte of a text the scanner stands between tokens.
	`BGT_ASSERT_NEXT(a_eot_idle, adv && eot_s1, scan.idle, "scanner not idle after end of text")

endmodule

// ----- rtl/bgt_scan.sv -----
// Scanner state and per-byte decode for the brace group tokenizer.
// Depends on bgt_pkg; produces up to two results for each stepped byte.
module bgt_scan #(
	parameter int MAX_TEXT_BYTES = 65536,
	parameter int MAX_NESTING    = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          text_byte,
	input  logic                end_of_text,
	output bgt_pkg::scan_out_t  scan
);

	localparam int PW = $clog2(MAX_TEXT_BYTES);
	localparam int LW = (PW > 17) ? PW : 17;
	localparam int NW = $clog2(MAX_NESTING + 1);

	bgt_pkg::mode_t mode_q, mode_mid, mode_d;
	logic [NW-1:0]  lvl_q, lvl_mid, lvl_d;
	logic [PW-1:0]  pos_q, pos_d;
	logic [PW-1:0]  begin_q, begin_mid, begin_d;
	logic           esc_q, esc_mid, esc_d;
	logic           prev_esc_q;

	logic is_open, is_close, is_bs, blank;
	logic word_end, start, stray, grp_close, ovf, ev_b, tail;
	logic [LW-1:0] posx, beginx, beginx_mid;
	bgt_pkg::result_t res_word, res_b, res_tail;

	assign is_open  = (text_byte == bgt_pkg::CH_OPEN);
	assign is_close = (text_byte == bgt_pkg::CH_CLOSE);
	assign is_bs    = (text_byte == bgt_pkg::CH_ESC);
	assign blank    = bgt_pkg::is_blank(text_byte);

	assign word_end  = (mode_q == bgt_pkg::MODE_WORD) && !esc_q && (blank || is_open || is_close);
	assign start     = (mode_q == bgt_pkg::MODE_IDLE) || word_end;
	assign stray     = start && is_close;
	assign grp_close = (mode_q == bgt_pkg::MODE_GROUP) && (lvl_q <= NW'(1)) && is_close
		&& !prev_esc_q;
	assign ovf       = (mode_q == bgt_pkg::MODE_GROUP) && !grp_close && is_open
		&& (lvl_q >= NW'(MAX_NESTING));
	assign ev_b      = stray || grp_close || ovf;

	// Next state: first the effect of the byte, then the end-of-text reset.
	always_comb begin
		mode_mid  = mode_q;
		lvl_mid   = lvl_q;
		begin_mid = begin_q;
		esc_mid   = esc_q;
		if (start) begin
			if (is_open) begin
				mode_mid  = bgt_pkg::MODE_GROUP;
				lvl_mid   = NW'(1);
				begin_mid = pos_q;
			end else if (is_close || blank) begin
				mode_mid = bgt_pkg::MODE_IDLE;
			end else begin
				mode_mid  = bgt_pkg::MODE_WORD;
				begin_mid = pos_q;
				esc_mid   = is_bs;
			end
		end else if (mode_q == bgt_pkg::MODE_WORD) begin
			esc_mid = !esc_q && is_bs;
		end else if (grp_close) begin
			mode_mid = bgt_pkg::MODE_IDLE;
			lvl_mid  = '0;
		end else if (is_open && !ovf) begin
			lvl_mid = lvl_q + NW'(1);
		end else if (is_close && !prev_esc_q) begin
			lvl_mid = lvl_q - NW'(1);
		end

		if (pos_q < PW'(MAX_TEXT_BYTES - 1)) begin
			pos_d = pos_q + PW'(1);
		end else begin
			pos_d = pos_q;
		end

		mode_d  = mode_mid;
		lvl_d   = lvl_mid;
		begin_d = begin_mid;
		esc_d   = esc_mid;
		if (end_of_text) begin
			mode_d  = bgt_pkg::MODE_IDLE;
			lvl_d   = '0;
			begin_d = '0;
			esc_d   = 1'b0;
			pos_d   = '0;
		end
	end

	assign tail       = end_of_text && (mode_mid != bgt_pkg::MODE_IDLE);
	assign posx       = LW'(pos_q);
	assign beginx     = LW'(begin_q);
	assign beginx_mid = LW'(begin_mid);

	// Results: word end, then a brace event, then the end-of-text flush.
	always_comb begin
		res_word.offset = beginx[15:0];
		res_word.length = 17'(posx - beginx);
		res_word.kind   = 1'b0;
		res_word.status = bgt_pkg::ST_OK;
		res_word.last   = 1'b0;

		res_b.last = 1'b0;
		if (grp_close) begin
			res_b.offset = beginx[15:0];
			res_b.length = 17'(posx - beginx + LW'(1));
			res_b.kind   = 1'b1;
			res_b.status = bgt_pkg::ST_OK;
		end else if (ovf) begin
			res_b.offset = posx[15:0];
			res_b.length = 17'd1;
			res_b.kind   = 1'b1;
			res_b.status = bgt_pkg::ST_OVERFLOW;
		end else begin
			res_b.offset = posx[15:0];
			res_b.length = 17'd1;
			res_b.kind   = 1'b0;
			res_b.status = bgt_pkg::ST_STRAY;
		end

		res_tail.offset = beginx_mid[15:0];
		res_tail.length = 17'(posx + LW'(1) - beginx_mid);
		res_tail.kind   = (mode_mid == bgt_pkg::MODE_GROUP);
		res_tail.last   = 1'b0;
		if (mode_mid == bgt_pkg::MODE_GROUP) begin
			res_tail.status = bgt_pkg::ST_UNTERM;
		end else if (esc_mid) begin
			res_tail.status = bgt_pkg::ST_DANGLING;
		end else begin
			res_tail.status = bgt_pkg::ST_OK;
		end

		scan.n_res = 2'(word_end) + 2'(ev_b) + 2'(tail);
		if (word_end) begin
			scan.r0 = res_word;
		end else if (ev_b) begin
			scan.r0 = res_b;
		end else begin
			scan.r0 = res_tail;
		end
		if (word_end && ev_b) begin
			scan.r1 = res_b;
		end else begin
			scan.r1 = res_tail;
		end
		scan.r0.last = (scan.n_res == 2'd1);
		scan.r1.last = 1'b1;
		scan.idle    = (mode_q == bgt_pkg::MODE_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= bgt_pkg::MODE_IDLE;
			lvl_q      <= '0;
			pos_q      <= '0;
			begin_q    <= '0;
			esc_q      <= 1'b0;
			prev_esc_q <= 1'b0;
		end else if (step) begin
			mode_q     <= mode_d;
			lvl_q      <= lvl_d;
			pos_q      <= pos_d;
			begin_q    <= begin_d;
			esc_q      <= esc_d;
			prev_esc_q <= is_bs && !end_of_text;
		end
	end

endmodule
